// File: design/log_spiral_point_generator_macros.svh
// ----------------------------------------------------------------------------
// log spiral point generator assertion macros
// concurrent assertion helpers clocked on clk_i, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef LOG_SPIRAL_POINT_GENERATOR_MACROS_SVH
`define LOG_SPIRAL_POINT_GENERATOR_MACROS_SVH

// same-cycle implication
`define LSG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsg assertion failed");

// next-cycle implication
`define LSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsg assertion failed");

`endif

// File: design/lsg_pkg.sv
// ----------------------------------------------------------------------------
// lsg_pkg
// shared widths, register indexes, control struct and cordic constant helpers
// ----------------------------------------------------------------------------
`default_nettype none

package lsg_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int ANGLE_FRAC_BITS_DEF   = 16;

  localparam int DW      = 36;  // cordic datapath, q2.30 with headroom
  localparam int SHW     = 6;   // shift / table index field
  localparam int OUT_W   = 52;
  localparam int ANG_W   = 20;
  localparam int SCALE_W = 15;
  localparam int GROW_W  = 15;
  localparam int STEP_W  = 17;
  localparam int ACC_W   = 21;
  localparam int CFG_W   = 20;
  localparam int MAG_W   = 31;
  localparam int M22_W   = 31;
  localparam int PROD_W  = 62;
  localparam int NX_W    = 16;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SCALE  = 2'd0;
  localparam cfg_idx_t CFG_GROWTH = 2'd1;
  localparam cfg_idx_t CFG_END    = 2'd2;
  localparam cfg_idx_t CFG_STEP   = 2'd3;

  typedef struct packed {
    logic           load;
    logic           hyp;
    logic           step;
    logic [SHW-1:0] shift;
  } cordic_ctl_t;

  // long division by shift and subtract, elaboration use only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/m) or atanh(1/m) in q62 by series
  function automatic logic [63:0] series_q62(input logic [63:0] m, input logic hyp);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p = div_u64(64'd1 << 62, m);
    sum = '0;
    for (int n = 0; n < 64; n++) begin
      if (p != 64'd0) begin
        term = div_u64(p, 64'(2 * n + 1));
        if (hyp || !n[0]) sum = sum + term;
        else sum = sum - term;
        p = div_u64(div_u64(p, m), m);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] q62_to_q30(input logic [63:0] v);
    return (v + (64'd1 << 31)) >> 32;
  endfunction

  function automatic logic [63:0] pi_quarter_q30();
    logic [63:0] pi4;
    pi4 = 64'd4 * series_q62(64'd5, 1'b0) - series_q62(64'd239, 1'b0);
    return q62_to_q30(pi4);
  endfunction

  function automatic logic [63:0] ln_two_q30();
    return q62_to_q30(64'd2 * series_q62(64'd3, 1'b1));
  endfunction

  function automatic logic [63:0] atan_q30(input int i);
    if (i == 0) return pi_quarter_q30();
    return q62_to_q30(series_q62(64'd1 << i, 1'b0));
  endfunction

  function automatic logic [63:0] atanh_q30(input int i);
    if (i == 0) return 64'd0;
    return q62_to_q30(series_q62(64'd1 << i, 1'b1));
  endfunction

  function automatic logic [63:0] gain_circ_inv(input int iters);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] t;
    x = 64'sd1 <<< 30;
    y = '0;
    z = '0;
    for (int i = 0; i < 64; i++) begin
      if (i < iters) begin
        dx = y >>> i;
        dy = x >>> i;
        t  = $signed(atan_q30(i));
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - t;
        end else begin
          x = x + dx; y = y - dy; z = z + t;
        end
      end
    end
    return div_u64((64'd1 << 60) + (64'(x) >> 1), 64'(x));
  endfunction

  function automatic logic [63:0] gain_hyp_inv(input int iters);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] t;
    int rep;
    int passes;
    x = 64'sd1 <<< 30;
    y = '0;
    z = '0;
    rep = 4;
    for (int i = 1; i <= 64; i++) begin
      if (i <= iters) begin
        passes = (i == rep) ? 2 : 1;
        for (int p = 0; p < 2; p++) begin
          if (p < passes) begin
            dx = y >>> i;
            dy = x >>> i;
            t  = $signed(atanh_q30(i));
            if (z >= 0) begin
              x = x + dx; y = y + dy; z = z - t;
            end else begin
              x = x - dx; y = y - dy; z = z + t;
            end
          end
        end
        if (i == rep) rep = 3 * rep + 1;
      end
    end
    return div_u64((64'd1 << 60) + (64'(x) >> 1), 64'(x));
  endfunction

endpackage

`default_nettype wire

// File: design/lsg_cordic.sv
// ----------------------------------------------------------------------------
// lsg_cordic
// shared cordic rotation unit, one circular or hyperbolic step per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lsg_cordic #(
  parameter int CORDIC_ITERATIONS = lsg_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                          clk_i,
  input  lsg_pkg::cordic_ctl_t          ctl_i,
  input  logic signed [lsg_pkg::DW-1:0] x0_i,
  input  logic signed [lsg_pkg::DW-1:0] y0_i,
  input  logic signed [lsg_pkg::DW-1:0] z0_i,
  output logic signed [lsg_pkg::DW-1:0] x_o,
  output logic signed [lsg_pkg::DW-1:0] y_o,
  output logic signed [lsg_pkg::DW-1:0] z_o
);
  import lsg_pkg::*;

  localparam int IW = $clog2(CORDIC_ITERATIONS + 1);

  logic signed [DW-1:0] tab_c [CORDIC_ITERATIONS+1];
  logic signed [DW-1:0] tab_h [CORDIC_ITERATIONS+1];

  for (genvar g = 0; g <= CORDIC_ITERATIONS; g++) begin : g_tab
    localparam logic signed [DW-1:0] ATAN_G  = DW'(atan_q30(g));
    localparam logic signed [DW-1:0] ATANH_G = DW'(atanh_q30(g));
    assign tab_c[g] = ATAN_G;
    assign tab_h[g] = ATANH_G;
  end

  logic signed [DW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic signed [DW-1:0] dx, dy, ang;
  logic                 pos;

  always_comb begin
    dx  = y_q >>> ctl_i.shift;
    dy  = x_q >>> ctl_i.shift;
    ang = ctl_i.hyp ? tab_h[ctl_i.shift[IW-1:0]] : tab_c[ctl_i.shift[IW-1:0]];
    pos = !z_q[DW-1];
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctl_i.load) begin
      x_d = x0_i;
      y_d = y0_i;
      z_d = z0_i;
    end else if (ctl_i.step) begin
      // hyperbolic mode flips the sign of the x update
      if (pos ^ ctl_i.hyp) x_d = x_q - dx;
      else x_d = x_q + dx;
      if (pos) begin
        y_d = y_q + dy;
        z_d = z_q - ang;
      end else begin
        y_d = y_q - dy;
        z_d = z_q + ang;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

// File: design/lsg_scale.sv
// ----------------------------------------------------------------------------
// lsg_scale
// two-stage coordinate scaler: magnitude product, then 2^n shift, round, clip
// ----------------------------------------------------------------------------
`default_nettype none

module lsg_scale (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [lsg_pkg::M22_W-1:0]        m22_i,
  input  logic signed [lsg_pkg::DW-1:0]    coord_i,
  input  logic [lsg_pkg::NX_W-1:0]         n_i,
  output logic                             valid_o,
  output logic [lsg_pkg::OUT_W-1:0]        res_o,
  output logic                             sat_o
);
  import lsg_pkg::*;

  localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};

  logic [DW-1:0]     abs_c;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q, vld_q;
  logic [NX_W-1:0]   n_q;

  assign abs_c = coord_i[DW-1] ? DW'(-coord_i) : DW'(coord_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(m22_i) * PROD_W'(abs_c[MAG_W-1:0]);
    neg_q  <= coord_i[DW-1];
    n_q    <= n_i;
  end

  logic [OUT_W-1:0]  lim, mag;
  logic [NX_W-1:0]   s;
  logic [5:0]        sh;
  logic [PROD_W:0]   rnd;
  logic              sat;

  always_comb begin
    lim = neg_q ? POS_LIM + OUT_W'(1) : POS_LIM;
    s   = n_q - NX_W'(44);
    sh  = 6'(NX_W'(44) - n_q);
    rnd = '0;
    sat = 1'b0;
    mag = '0;
    if (n_q >= NX_W'(44)) begin
      if (prod_q != '0 && (s >= NX_W'(52) || prod_q > PROD_W'(lim >> s[5:0]))) begin
        sat = 1'b1;
        mag = lim;
      end else begin
        mag = OUT_W'(prod_q << s[5:0]);
      end
    end else begin
      // round half up on the magnitude
      rnd = ({1'b0, prod_q} + ((PROD_W+1)'(1) << (sh - 6'd1))) >> sh;
      if (rnd > (PROD_W+1)'(lim)) begin
        sat = 1'b1;
        mag = lim;
      end else begin
        mag = rnd[OUT_W-1:0];
      end
    end
  end

  assign valid_o = vld_q;
  assign res_o   = neg_q ? OUT_W'(-mag) : mag;
  assign sat_o   = sat;

endmodule

`default_nettype wire

// File: design/log_spiral_point_generator.sv
// ----------------------------------------------------------------------------
// log_spiral_point_generator
// logarithmic spiral sampler r = a*exp(k*phi) using a shared cordic unit
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream (tdata bit 0 = restart) yields one
// point on the master stream. The angle starts at zero, grows by angle_step
// per request and the point at end_angle comes out with tlast set, after
// which the angle wraps to zero. tuser on the master side flags a clipped
// coordinate. Registers are written through the cfg channel (always ready);
// the user must write them only while the block is idle; it does not check.
// Flow: the angle is reduced, the ln2 split makes a reciprocal estimate, a
// remainder and one correction, then the single cordic unit is stepped once
// per cycle through a circular pass then a hyperbolic pass. One request is in
// work at a time; the sequencer returns to idle before it takes the next.
// s_tready_o is high only while the sequencer is idle; a finished point sits
// in the output register, so a new request is taken while it waits. If the
// receiver stalls, the next point waits in the final state for the slot.
// Reset clears the angle, restores register defaults and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "log_spiral_point_generator_macros.svh"

module log_spiral_point_generator #(
  parameter int CORDIC_ITERATIONS = lsg_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS   = lsg_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [7:0]                  s_tdata_i,   // [0] restart
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [127:0]                m_tdata_o,   // [51:0] x_coord, [103:52] y_coord,
                                                   // [123:104] sample_angle
  output logic                        m_tlast_o,   // last_point
  output logic                        m_tuser_o,   // [0] saturated
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  lsg_pkg::cfg_idx_t           cfg_addr_i,
  input  logic [lsg_pkg::CFG_W-1:0]   cfg_data_i
);
  import lsg_pkg::*;

  localparam int ZWW = (50 - ANGLE_FRAC_BITS > DW) ? 50 - ANGLE_FRAC_BITS : DW;
  localparam int TSH = ANGLE_FRAC_BITS - 16;
  localparam int TW  = 51 - ANGLE_FRAC_BITS;
  localparam int NQ  = (TW - 29 > 1) ? TW - 29 : 1;
  localparam int JW  = 2;
  localparam int RW  = ((TW > 31) ? TW : 31) + 1;

  localparam logic [63:0] PQ64 = pi_quarter_q30();
  localparam logic signed [DW-1:0] PI_Q   = DW'(PQ64 * 64'd4);
  localparam logic signed [DW-1:0] HPI_Q  = DW'(PQ64 * 64'd2);
  localparam logic signed [DW-1:0] TPI_Q  = DW'(PQ64 * 64'd8);
  localparam logic [ZWW-1:0]       TPI_U  = ZWW'(PQ64 * 64'd8);
  localparam logic [RW-1:0]        LN2_Q  = RW'(ln_two_q30());
  localparam logic [NQ:0]          RCP_Q  = (NQ+1)'(div_u64(64'd1 << TW, 64'(LN2_Q)));
  localparam logic signed [DW-1:0] GC_Q   = DW'(gain_circ_inv(CORDIC_ITERATIONS));
  localparam logic signed [DW-1:0] GH_Q   = DW'(gain_hyp_inv(CORDIC_ITERATIONS));

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RED  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_CIRC = 4'd3;
  localparam logic [3:0] S_HLD  = 4'd4;
  localparam logic [3:0] S_HYP  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_SCX  = 4'd7;
  localparam logic [3:0] S_SCY  = 4'd8;
  localparam logic [3:0] S_SCW  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // configuration
  logic [SCALE_W-1:0] scale_q;
  logic [GROW_W-1:0]  growth_q;
  logic [ANG_W-1:0]   end_q;
  logic [STEP_W-1:0]  step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_W'(1280);
      growth_q <= GROW_W'(16384);
      end_q    <= ANG_W'(102944);
      step_q   <= STEP_W'(66);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        CFG_GROWTH: growth_q <= cfg_data_i[GROW_W-1:0];
        CFG_END:    end_q    <= cfg_data_i[ANG_W-1:0];
        CFG_STEP:   step_q   <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [3:0]         state_q, state_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [ANG_W-1:0]   phi_q, phi_d;
  logic               last_q, last_d;
  logic [ZWW-1:0]     zw_q, zw_d;
  logic [RW-1:0]      rem_q, rem_d;
  logic [NQ-1:0]      n_q, n_d;
  logic [JW-1:0]      j_q, j_d;
  logic [SHW-1:0]     iter_q, iter_d;
  logic [7:0]         rep_q, rep_d;
  logic               again_q, again_d;
  logic               flip_q, flip_d;
  logic signed [DW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [M22_W-1:0]   m22_q, m22_d;
  logic [OUT_W-1:0]   rx_q, rx_d;
  logic [OUT_W-1:0]   ry_q, ry_d;
  logic               rsat_q, rsat_d;

  logic [OUT_W-1:0]   ox_q, oy_q;
  logic [ANG_W-1:0]   oang_q;
  logic               olast_q, osat_q, ovalid_q;

  logic               accept;
  logic [ACC_W-1:0]   phi_sel;
  logic [ANG_W-1:0]   phi_new;
  logic [34:0]        kprod;
  logic [TW-1:0]      t_w;
  logic signed [DW-1:0] zs;
  logic               fold_flip;
  logic [TW+NQ:0]     nprod;
  logic [RW-1:0]      nln2;
  logic signed [DW-1:0] esum;
  logic [31:0]        e_u;
  logic [46:0]        me_prod;

  cordic_ctl_t          cctl;
  logic signed [DW-1:0] cx0, cy0, cz0, cxo, cyo, czo;

  logic                 sc_valid, sc_vo, sc_sat;
  logic signed [DW-1:0] sc_coord;
  logic [OUT_W-1:0]     sc_res;

  assign accept     = s_tvalid_i && s_tready_o;
  assign s_tready_o = (state_q == S_IDLE);
  assign phi_sel    = s_tdata_i[0] ? '0 : acc_q;
  assign phi_new    = (phi_sel < ACC_W'(end_q)) ? phi_sel[ANG_W-1:0] : end_q;
  assign kprod      = 35'(growth_q) * 35'(phi_new);

  if (TSH >= 0) begin : g_tr
    assign t_w = TW'(kprod >> TSH);
  end else begin : g_tl
    assign t_w = TW'({kprod, {(-TSH){1'b0}}});
  end

  // fold the reduced angle into [-pi/2, pi/2]
  always_comb begin
    zs = $signed(zw_q[DW-1:0]);
    fold_flip = 1'b0;
    if (zs > PI_Q) zs = zs - TPI_Q;
    if (zs > HPI_Q) begin
      zs = zs - PI_Q;
      fold_flip = 1'b1;
    end else if (zs < -HPI_Q) begin
      zs = zs + PI_Q;
      fold_flip = 1'b1;
    end
  end

  // reciprocal estimate of t / ln2 is exact or one low
  assign nprod   = (TW+NQ+1)'(rem_q[TW-1:0]) * (TW+NQ+1)'(RCP_Q);
  assign nln2    = RW'(n_q) * LN2_Q;
  assign esum    = cxo + cyo;
  assign e_u     = esum[DW-1] ? 32'd0 : esum[31:0];
  assign me_prod = 47'(scale_q) * 47'(e_u);

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    phi_d   = phi_q;
    last_d  = last_q;
    zw_d    = zw_q;
    rem_d   = rem_q;
    n_d     = n_q;
    j_d     = j_q;
    iter_d  = iter_q;
    rep_d   = rep_q;
    again_d = again_q;
    flip_d  = flip_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    m22_d   = m22_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    rsat_d  = rsat_q;
    cctl    = '0;
    cctl.shift = iter_q;
    cx0 = GC_Q;
    cy0 = '0;
    cz0 = zs;
    sc_valid = 1'b0;
    sc_coord = cx_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (phi_sel < ACC_W'(end_q)) begin
            last_d = 1'b0;
            acc_d  = phi_sel + ACC_W'(step_q);
          end else begin
            last_d = 1'b1;
            acc_d  = '0;
          end
          phi_d   = phi_new;
          zw_d    = ZWW'({phi_new, {(30 - ANGLE_FRAC_BITS){1'b0}}});
          rem_d   = RW'(t_w);
          n_d     = '0;
          j_d     = '0;
          state_d = S_RED;
        end
      end
      S_RED: begin
        if (zw_q >= TPI_U) begin
          zw_d = zw_q - TPI_U;
        end else begin
          cctl.load = 1'b1;
          flip_d    = fold_flip;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        // split by ln2: estimate, remainder, then one correction step
        if (j_q == JW'(0)) begin
          n_d = nprod[TW +: NQ];
          j_d = JW'(1);
        end else if (j_q == JW'(1)) begin
          rem_d = rem_q - nln2;
          j_d   = JW'(2);
        end else begin
          if (rem_q >= LN2_Q) begin
            rem_d = rem_q - LN2_Q;
            n_d   = n_q + NQ'(1);
          end
          iter_d  = '0;
          state_d = S_CIRC;
        end
      end
      S_CIRC: begin
        cctl.step = 1'b1;
        if (iter_q == SHW'(CORDIC_ITERATIONS - 1)) state_d = S_HLD;
        else iter_d = iter_q + SHW'(1);
      end
      S_HLD: begin
        cx_d      = flip_q ? -cxo : cxo;
        cy_d      = flip_q ? -cyo : cyo;
        cctl.load = 1'b1;
        cx0       = GH_Q;
        cz0       = DW'(rem_q);
        iter_d    = SHW'(1);
        rep_d     = 8'd4;
        again_d   = 1'b0;
        state_d   = S_HYP;
      end
      S_HYP: begin
        cctl.step = 1'b1;
        cctl.hyp  = 1'b1;
        // shifts 4, 13, 40 are taken twice
        if (8'(iter_q) == rep_q && !again_q) begin
          again_d = 1'b1;
        end else begin
          again_d = 1'b0;
          if (8'(iter_q) == rep_q) rep_d = rep_q * 8'd3 + 8'd1;
          if (iter_q == SHW'(CORDIC_ITERATIONS)) state_d = S_MUL;
          else iter_d = iter_q + SHW'(1);
        end
      end
      S_MUL: begin
        m22_d   = me_prod[46:16];
        state_d = S_SCX;
      end
      S_SCX: begin
        sc_valid = 1'b1;
        sc_coord = cx_q;
        state_d  = S_SCY;
      end
      S_SCY: begin
        sc_valid = 1'b1;
        sc_coord = cy_q;
        rx_d     = sc_res;
        rsat_d   = sc_sat;
        state_d  = S_SCW;
      end
      S_SCW: begin
        cy_d    = $signed(DW'(0));
        ry_d    = sc_res;
        rsat_d  = rsat_q | sc_sat;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ovalid_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    phi_q   <= phi_d;
    last_q  <= last_d;
    zw_q    <= zw_d;
    rem_q   <= rem_d;
    n_q     <= n_d;
    j_q     <= j_d;
    iter_q  <= iter_d;
    rep_q   <= rep_d;
    again_q <= again_d;
    flip_q  <= flip_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    m22_q   <= m22_d;
    rx_q    <= rx_d;
    ry_q    <= ry_d;
    rsat_q  <= rsat_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == S_DONE && !ovalid_q) begin
      ovalid_q <= 1'b1;
    end else if (m_tready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && !ovalid_q) begin
      ox_q    <= rx_q;
      oy_q    <= ry_q;
      oang_q  <= phi_q;
      olast_q <= last_q;
      osat_q  <= rsat_q;
    end
  end

  lsg_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i (clk_i),
    .ctl_i (cctl),
    .x0_i  (cx0),
    .y0_i  (cy0),
    .z0_i  (cz0),
    .x_o   (cxo),
    .y_o   (cyo),
    .z_o   (czo)
  );

  lsg_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .m22_i   (m22_q),
    .coord_i (sc_coord),
    .n_i     (NX_W'(n_q)),
    .valid_o (sc_vo),
    .res_o   (sc_res),
    .sat_o   (sc_sat)
  );

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = {4'd0, oang_q, oy_q, ox_q};
  assign m_tlast_o  = olast_q;
  assign m_tuser_o  = osat_q;

  // the scaler delivers exactly in the cycles where results are captured
  `LSG_ASSERT_IMPL(a_scale_timing, (state_q == S_SCY) || (state_q == S_SCW), sc_vo)
  // the rotation residue of a circular pass stays within a quarter turn
  `LSG_ASSERT_IMPL(a_circ_resid, state_q == S_HLD, (czo < HPI_Q) && (czo > -HPI_Q))
  // the end point wraps the angle back to zero
  `LSG_ASSERT_NEXT(a_wrap, accept && !(phi_sel < ACC_W'(end_q)), acc_q == '0)
  // a clipped point carries a limit value in one coordinate
  `LSG_ASSERT_IMPL(a_sat_lim, m_tvalid_o && m_tuser_o,
    (ox_q == {1'b0, {(OUT_W-1){1'b1}}}) || (ox_q == {1'b1, {(OUT_W-1){1'b0}}}) ||
    (oy_q == {1'b0, {(OUT_W-1){1'b1}}}) || (oy_q == {1'b1, {(OUT_W-1){1'b0}}}))

endmodule

`default_nettype wire
